// ----- rtl/core/aas_pkg.sv -----
// Package with shared types and constants of the activity score block.
package aas_pkg;

   localparam int unsigned RING_DEPTH_DEF = 8;
   localparam logic [14:0] FULL_SCORE = 15'd25600;
   localparam logic [14:0] ONE_G_COUNTS = 15'd16384;

   localparam logic [2:0] CSR_WINDOW_LENGTH = 3'd0;
   localparam logic [2:0] CSR_LOW_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_HIGH_THRESHOLD = 3'd2;
   localparam logic [2:0] CSR_SCORE_FLOOR = 3'd3;
   localparam logic [2:0] CSR_SCORE_CEILING = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_ACCUM,
      ST_MEAN,
      ST_MAP_MUL,
      ST_MAP_DIV,
      ST_CLAMP,
      ST_RING_SUM,
      ST_RING_DIV,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/core/accel_activity_score_top.sv -----
// Top level of the accelerometer activity score block.
//
// A request that does not close a window passes through squaring of the three
// axes, the 17-step square root and the step that adds the deviation. A request
// that closes a window goes on through three 32-step restoring divides (window
// mean, linear map, ring mean), the clamp and ring write, and a walk over the
// score ring memory, one entry a cycle. The map divide is skipped when the mean
// lies at or outside the thresholds. A finished result waits in the output
// register; the next request is taken once the result has left. The score ring
// holds no reset state: only the filled entries are ever summed.
module accel_activity_score_top #(
   parameter int unsigned RING_DEPTH = aas_pkg::RING_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_filtered_score,
   output logic [14:0]        rsp_window_score,
   output logic [15:0]        rsp_mean_deviation,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import aas_pkg::*;

   localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int unsigned FW = $clog2(RING_DEPTH + 1);

   logic [7:0]  window_length_ff;
   logic [15:0] low_threshold_ff, high_threshold_ff;
   logic [14:0] score_floor_ff, score_ceiling_ff;

   state_type   state_ff, state_in;
   logic [15:0] ax_ff, ay_ff, az_ff;
   logic [33:0] sq_ff, sq_in;
   logic [33:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  axis_ff, axis_in;
   logic [23:0] dev_sum_ff, dev_sum_in;
   logic [7:0]  taken_ff, taken_in;
   logic [31:0] num_ff, num_in;
   logic [23:0] den_ff, den_in;
   logic [23:0] quo_ff, quo_in;
   logic [24:0] drem_ff, drem_in;
   logic [15:0] mean_ff, mean_in;
   logic [14:0] score_ff, score_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] rd_idx_ff, rd_idx_in;
   logic [23:0] ring_sum_ff, ring_sum_in;
   logic        out_valid_ff, out_valid_in;
   logic [14:0] out_filt_ff, out_filt_in;
   logic [14:0] out_win_ff, out_win_in;
   logic [15:0] out_mean_ff, out_mean_in;

   logic [14:0] ring_mem [RING_DEPTH];
   logic [14:0] ring_rd_ff;
   logic        ring_we;
   logic [PW-1:0] ring_raddr;

   logic [15:0] axis_mag;
   logic [31:0] axis_sq;
   logic [33:0] trial;
   logic [24:0] dshift;
   logic [16:0] dev;
   logic [7:0]  wl;
   logic [8:0]  count;
   logic [14:0] clamp_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= 8'd50;
         low_threshold_ff  <= 16'd819;
         high_threshold_ff <= 16'd32768;
         score_floor_ff    <= 15'd0;
         score_ceiling_ff  <= FULL_SCORE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:  window_length_ff  <= csr_data[7:0];
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_data;
            CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_data;
            CSR_SCORE_FLOOR:    score_floor_ff    <= csr_data[14:0];
            CSR_SCORE_CEILING:  score_ceiling_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   assign ring_raddr = rd_idx_ff[PW-1:0];

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[pos_ff] <= score_ff;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dev_sum_ff   <= '0;
         taken_ff     <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dev_sum_ff   <= dev_sum_in;
         taken_ff     <= taken_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !req_stall) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
      end
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      axis_ff     <= axis_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      drem_ff     <= drem_in;
      mean_ff     <= mean_in;
      score_ff    <= score_in;
      rd_idx_ff   <= rd_idx_in;
      ring_sum_ff <= ring_sum_in;
      out_filt_ff <= out_filt_in;
      out_win_ff  <= out_win_in;
      out_mean_ff <= out_mean_in;
   end

   always_comb begin
      state_in     = state_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      dev_sum_in   = dev_sum_ff;
      taken_in     = taken_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      drem_in      = drem_ff;
      mean_in      = mean_ff;
      score_in     = score_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      ring_sum_in  = ring_sum_ff;
      out_valid_in = out_valid_ff;
      out_filt_in  = out_filt_ff;
      out_win_in   = out_win_ff;
      out_mean_in  = out_mean_ff;
      ring_we      = 1'b0;
      req_stall    = 1'b1;

      case (axis_ff)
         2'd0:    axis_mag = ax_ff[15] ? 16'(-ax_ff) : ax_ff;
         2'd1:    axis_mag = ay_ff[15] ? 16'(-ay_ff) : ay_ff;
         default: axis_mag = az_ff[15] ? 16'(-az_ff) : az_ff;
      endcase
      axis_sq = axis_mag * axis_mag;
      trial   = {rem_ff[31:0], sq_ff[33:32]} - {15'd0, root_ff, 2'b01};
      dshift  = {drem_ff[23:0], num_ff[31]};
      dev     = (root_ff >= 17'(ONE_G_COUNTS)) ? root_ff - 17'(ONE_G_COUNTS)
                                               : 17'(ONE_G_COUNTS) - root_ff;
      wl      = (window_length_ff == 8'd0) ? 8'd1 : window_length_ff;
      count   = {1'b0, taken_ff} + 9'd1;
      clamp_lo = (score_ff < score_floor_ff) ? score_floor_ff : score_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = out_valid_ff;
            if (req_valid && !out_valid_ff) begin
               sq_in   = '0;
               axis_in = 2'd0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in = sq_ff + {2'd0, axis_sq};
            if (axis_ff == 2'd2) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            sq_in = {sq_ff[31:0], 2'b00};
            if (!trial[33]) begin
               rem_in  = trial;
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[31:0], sq_ff[33:32]};
               root_in = {root_ff[15:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            dev_sum_in = dev_sum_ff + 24'(dev);
            if (count < {1'b0, wl}) begin
               taken_in = count[7:0];
               state_in = ST_IDLE;
            end else begin
               num_in   = {8'd0, dev_sum_in};
               den_in   = 24'(count);
               quo_in   = '0;
               drem_in  = '0;
               step_in  = '0;
               taken_in = '0;
               dev_sum_in = '0;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN, ST_MAP_DIV, ST_RING_DIV: begin
            num_in = {num_ff[30:0], 1'b0};
            if (dshift >= {1'b0, den_ff}) begin
               drem_in = dshift - {1'b0, den_ff};
               quo_in  = {quo_ff[22:0], 1'b1};
            end else begin
               drem_in = dshift;
               quo_in  = {quo_ff[22:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               case (state_ff)
                  ST_MEAN: begin
                     mean_in  = quo_in[15:0];
                     state_in = ST_MAP_MUL;
                  end
                  ST_MAP_DIV: begin
                     score_in = quo_in[14:0];
                     state_in = ST_CLAMP;
                  end
                  default: begin
                     out_filt_in  = quo_in[14:0];
                     out_win_in   = score_ff;
                     out_mean_in  = mean_ff;
                     out_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MAP_MUL: begin
            quo_in  = '0;
            drem_in = '0;
            step_in = '0;
            if (mean_ff <= low_threshold_ff) begin
               score_in = '0;
               state_in = ST_CLAMP;
            end else if (mean_ff >= high_threshold_ff) begin
               score_in = FULL_SCORE;
               state_in = ST_CLAMP;
            end else begin
               num_in   = {16'd0, 16'(mean_ff - low_threshold_ff)} * {17'd0, FULL_SCORE};
               den_in   = 24'(high_threshold_ff - low_threshold_ff);
               state_in = ST_MAP_DIV;
            end
         end
         ST_CLAMP: begin
            score_in = (clamp_lo > score_ceiling_ff) ? score_ceiling_ff : clamp_lo;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            ring_we = 1'b1;
            pos_in  = (32'(pos_ff) == RING_DEPTH - 1) ? '0 : pos_ff + PW'(1);
            if (32'(fill_ff) < RING_DEPTH) begin
               fill_in = fill_ff + FW'(1);
            end
            rd_idx_in   = '0;
            ring_sum_in = '0;
            step_in     = '0;
            state_in    = ST_RING_SUM;
         end
         ST_RING_SUM: begin
            if (step_ff != 5'd0) begin
               ring_sum_in = ring_sum_ff + 24'(ring_rd_ff);
            end
            step_in = 5'd1;
            if (rd_idx_ff == fill_ff) begin
               num_in   = {8'd0, ring_sum_in};
               den_in   = 24'(fill_ff);
               quo_in   = '0;
               drem_in  = '0;
               step_in  = '0;
               state_in = ST_RING_DIV;
            end else begin
               rd_idx_in = rd_idx_ff + FW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_filtered_score = out_filt_ff;
   assign rsp_window_score   = out_win_ff;
   assign rsp_mean_deviation = out_mean_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= RING_DEPTH) else $error("ring fill exceeds depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_score))
      else $error("result dropped while stalled");
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MEAN |-> taken_ff == 8'd0) else $error("window count not cleared");
`endif

endmodule

// ----- tb/sv/accel_activity_score_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts activity score results and compares them with the block.
module accel_activity_score_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [14:0]        rsp_filtered_score,
   input  logic [14:0]        rsp_window_score,
   input  logic [15:0]        rsp_mean_deviation,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);
   import aas_pkg::*;

   localparam int unsigned DEPTH = RING_DEPTH_DEF;

   typedef struct {
      logic [14:0] filtered;
      logic [14:0] window;
      logic [15:0] mean;
   } score_result_type;

   score_result_type score_queue[$];

   logic [7:0]  win_len;
   logic [15:0] thr_low;
   logic [15:0] thr_high;
   logic [14:0] clamp_floor;
   logic [14:0] clamp_ceiling;

   logic [23:0] dev_total;
   logic [7:0]  taken;
   logic [14:0] ring[DEPTH];
   int unsigned ring_pos;
   int unsigned ring_count;

   function automatic longint unsigned magnitude_root(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   task automatic absorb_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                input logic signed [15:0] az);
      longint signed sx, sy, sz;
      longint unsigned m, dev, wl, cnt, mean, score, total;
      score_result_type res;
      sx = ax;
      sy = ay;
      sz = az;
      m = magnitude_root(sx * sx + sy * sy + sz * sz);
      dev = (m >= 16384) ? m - 16384 : 16384 - m;
      wl = (win_len == 0) ? 1 : win_len;
      dev_total = dev_total + dev[23:0];
      cnt = taken + 1;
      if (cnt < wl) begin
         taken = cnt[7:0];
         return;
      end
      mean = dev_total / cnt;
      dev_total = '0;
      taken = '0;
      if (mean <= thr_low) score = 0;
      else if (mean >= thr_high) score = 25600;
      else score = ((mean - thr_low) * 25600) / (thr_high - thr_low);
      if (score < clamp_floor) score = clamp_floor;
      if (score > clamp_ceiling) score = clamp_ceiling;
      ring[ring_pos] = score[14:0];
      ring_pos = (ring_pos + 1) % DEPTH;
      if (ring_count < DEPTH) ring_count++;
      total = 0;
      for (int i = 0; i < ring_count; i++) total += ring[i];
      res.filtered = 15'(total / ring_count);
      res.window = score[14:0];
      res.mean = mean[15:0];
      score_queue.push_back(res);
   endtask

   always @(posedge clock) begin
      score_result_type want;
      if (reset) begin
         win_len = 8'd50;
         thr_low = 16'd819;
         thr_high = 16'd32768;
         clamp_floor = 15'd0;
         clamp_ceiling = 15'd25600;
         dev_total = '0;
         taken = '0;
         ring_pos = 0;
         ring_count = 0;
         score_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: win_len = csr_data[7:0];
               CSR_LOW_THRESHOLD: thr_low = csr_data;
               CSR_HIGH_THRESHOLD: thr_high = csr_data;
               CSR_SCORE_FLOOR: clamp_floor = csr_data[14:0];
               CSR_SCORE_CEILING: clamp_ceiling = csr_data[14:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (score_queue.size() == 0) begin
               $display("%0t: unexpected result filtered=%0d window=%0d mean=%0d", $time,
                        rsp_filtered_score, rsp_window_score, rsp_mean_deviation);
               fail_count++;
            end else begin
               want = score_queue.pop_front();
               if (want.filtered !== rsp_filtered_score) begin
                  $display("%0t: filtered_score expected %0d actual %0d", $time,
                           want.filtered, rsp_filtered_score);
                  fail_count++;
               end
               if (want.window !== rsp_window_score) begin
                  $display("%0t: window_score expected %0d actual %0d", $time,
                           want.window, rsp_window_score);
                  fail_count++;
               end
               if (want.mean !== rsp_mean_deviation) begin
                  $display("%0t: mean_deviation expected %0d actual %0d", $time,
                           want.mean, rsp_mean_deviation);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) absorb_sample(req_accel_x, req_accel_y, req_accel_z);
      end
      pending = score_queue.size();
   end

endmodule

// ----- tb/sv/accel_activity_score_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top that drives samples and settings into the activity score block.
module accel_activity_score_top_test;
   import aas_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_accel_x;
   logic signed [15:0] req_accel_y;
   logic signed [15:0] req_accel_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [14:0]        rsp_filtered_score;
   logic [14:0]        rsp_window_score;
   logic [15:0]        rsp_mean_deviation;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;
   int                 fail_count;
   int                 pending;
   bit                 hold_output;

   accel_activity_score_top u_top (.*);

   accel_activity_score_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      int gap;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] wl, input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] fl, input logic [15:0] ce);
      logic [15:0] vals[5];
      logic [2:0]  idx[5];
      vals = '{wl, lo, hi, fl, ce};
      idx = '{CSR_WINDOW_LENGTH, CSR_LOW_THRESHOLD, CSR_HIGH_THRESHOLD, CSR_SCORE_FLOOR,
              CSR_SCORE_CEILING};
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] near_value(input int centre, input int spread);
      int v;
      v = centre + $urandom_range(0, 2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   task automatic send_random_sample();
      logic [15:0] f[3];
      int          spread;
      int          axis;
      int          mode;
      logic [15:0] corner[5];
      corner = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
         foreach (f[i]) f[i] = 16'($urandom_range(0, 65535));
      end else if (mode < 9) begin
         case ($urandom_range(0, 3))
            0: spread = 50;
            1: spread = 800;
            2: spread = 4000;
            default: spread = 14000;
         endcase
         axis = $urandom_range(0, 2);
         foreach (f[i]) begin
            if (i == axis) f[i] = near_value($urandom_range(0, 1) ? 16384 : -16384, spread);
            else f[i] = near_value(0, spread);
         end
      end else begin
         foreach (f[i]) f[i] = corner[$urandom_range(0, 4)];
      end
      send_sample(f[0], f[1], f[2]);
   endtask

   initial begin
      int wl, lo, hi, fl, ce, n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      csr_write = 1'b0;
      csr_index = CSR_WINDOW_LENGTH;
      csr_data = '0;
      hold_output = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(1, 819, 32768, 0, 25600);
      send_sample(16'sd0, 16'sd0, 16'sd0);
      send_sample(16'sd16384, 16'sd0, 16'sd0);
      send_sample(16'sd0, -16'sd16384, 16'sd0);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'sd0, 16'sd0);
      send_sample(16'h7FFF, 16'h8000, 16'sd1);
      send_sample(16'sd1, -16'sd1, 16'sd0);
      send_sample(16'sd11585, 16'sd11585, 16'sd0);
      send_sample(16'sd17384, 16'sd0, 16'sd0);
      wait_idle();
      set_config(0, 0, 65535, 0, 25600);
      send_sample(16'sd20000, 16'sd0, 16'sd0);
      send_sample(16'sd5000, 16'sd3000, -16'sd2000);
      wait_idle();
      set_config(5, 100, 5000, 0, 25600);
      send_sample(16'sd16000, 16'sd100, 16'sd0);
      send_sample(16'sd0, 16'sd17000, 16'sd0);
      send_sample(16'sd0, 16'sd0, -16'sd15000);
      wait_idle();
      set_config(2, 100, 5000, 0, 25600);
      send_sample(16'sd16384, 16'sd2000, 16'sd0);
      wait_idle();
      set_config(1, 65535, 1, 0, 25600);
      send_sample(16'sd0, 16'sd0, 16'sd0);
      send_sample(16'sd16384, 16'sd0, 16'sd0);
      wait_idle();
      set_config(1, 0, 65535, 30000, 0);
      send_sample(16'sd3000, 16'sd0, 16'sd0);
      wait_idle();
      set_config(1, 0, 1, 32767, 32767);
      send_sample(16'sd0, 16'sd9000, 16'sd0);
      send_sample(16'h8000, 16'h7FFF, 16'h8000);
      wait_idle();

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 9))
            0: wl = 0;
            1, 2: wl = 1;
            3, 4, 5: wl = $urandom_range(2, 4);
            default: wl = $urandom_range(1, 12);
         endcase
         if (ph == 2) wl = 1;
         if (ph == 6) wl = 255;
         if ($urandom_range(0, 3) == 0) begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(1, 65535);
         end else begin
            lo = $urandom_range(0, 3000);
            hi = lo + $urandom_range(1, 30000);
         end
         if ($urandom_range(0, 2) == 0) begin
            fl = $urandom_range(0, 32767);
            ce = $urandom_range(0, 32767);
         end else begin
            fl = $urandom_range(0, 2000);
            ce = $urandom_range(20000, 25600);
         end
         set_config(16'(wl), 16'(lo), 16'(hi), 16'(fl), 16'(ce));
         if (ph == 2) hold_output = 1'b1;
         n = (wl == 255) ? 255 : 90;
         repeat (n) send_random_sample();
         wait_idle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("PASS accel_activity_score_top");
      end else begin
         $display("FAIL accel_activity_score_top");
      end
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  rsp_stall <= 1'b0;
                  repeat ($urandom_range(20, 200)) @(posedge clock);
               end
               3: begin
                  rsp_stall <= 1'b1;
                  repeat ($urandom_range(20, 150)) @(posedge clock);
               end
               default: begin
                  rsp_stall <= 1'($urandom_range(0, 1));
                  repeat ($urandom_range(1, 4)) @(posedge clock);
               end
            endcase
         end
      end
   end

   initial begin
      #5000000;
      $display("FAIL accel_activity_score_top");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/aas_pkg.sv
rtl/core/accel_activity_score_top.sv
tb/sv/accel_activity_score_checker.sv
tb/sv/accel_activity_score_top_test.sv
